@@ hdl/lag_pkg.sv @@
package lag_pkg;

  // Default largest side length of the grid.
  localparam int SIDE_MAX_DEFAULT = 32;

  // Field widths of the ports.
  localparam int OP_W    = 2;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int SIDE_W  = 6;
  localparam int COUNT_W = 11;

  // The live count saturates at the largest value of its field.
  localparam int COUNT_MAX = 2047;

  // Side length after reset.
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

  // Life rule B3/S23.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_LOW    = 4'd2;
  localparam logic [3:0] STAY_HIGH   = 4'd3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } lag_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH,
    ST_DONE
  } lag_state_t;

  // Per-row control handed to the row update logic.
  typedef struct packed {
    lag_op_t op;
    logic    row_active;
    logic    row_hit;
    logic    val;
  } lag_upd_ctrl_t;

endpackage

@@ hdl/life_automaton_grid_top.sv @@
// Each transfer runs the grid rows once around the ring of row cells, one row
// per cycle past the update logic; then a flush state drains the count, and the
// result waits in the done state until the result register can take it. The next
// input is accepted only after the result is loaded.
// Synchronous active-high reset clears every cell to dead, sets the side
// length to 32 and empties the result register.
module life_automaton_grid_top #(
  parameter int SIDE_MAX = lag_pkg::SIDE_MAX_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lag_pkg::SIDE_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lag_pkg::OP_W-1:0]     op,
  input  logic [lag_pkg::ROW_W-1:0]    row,
  input  logic [lag_pkg::COL_W-1:0]    col,
  input  logic                         cell_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         cell_out,
  output logic [lag_pkg::COUNT_W-1:0]  live_count
);

  localparam int IDX_W = $clog2(SIDE_MAX);
  localparam int CMP_W = ((IDX_W + 1) > lag_pkg::SIDE_W ? (IDX_W + 1) : lag_pkg::SIDE_W) + 1;
  localparam int SUM_W = $clog2(SIDE_MAX * SIDE_MAX + 1);

  lag_pkg::lag_state_t state, state_next;

  logic [lag_pkg::SIDE_W-1:0] side_length;
  logic [CMP_W-1:0]           active_n;
  logic [CMP_W-1:0]           n_q;
  lag_pkg::lag_op_t           op_q;
  logic [lag_pkg::ROW_W-1:0]  row_q;
  logic [lag_pkg::COL_W-1:0]  col_q;
  logic                       val_q;
  logic [IDX_W-1:0]           step;
  logic [SIDE_MAX-1:0]        prev_row;
  logic [SIDE_MAX-1:0]        cnt_row;
  logic                       cnt_row_v;
  logic [SUM_W-1:0]           total;
  logic                       hit_bit;

  logic                       accept;
  logic                       shift;
  logic                       load_out;
  logic                       last_step;
  logic                       in_square;
  logic                       row_match;
  logic [SIDE_MAX-1:0]        col_mask;
  logic [SIDE_MAX-1:0]        col_sel;
  logic [SIDE_MAX-1:0]        above;
  logic [SIDE_MAX-1:0]        below;
  logic [SIDE_MAX-1:0]        new_row;
  logic [SIDE_MAX-1:0]        rows [SIDE_MAX];
  lag_pkg::lag_upd_ctrl_t     ctrl;

  function automatic logic [SUM_W-1:0] popcount(input logic [SIDE_MAX-1:0] v);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < SIDE_MAX; i++) begin
      s = s + SUM_W'(v[i]);
    end
    return s;
  endfunction

  // Side length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= lag_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      side_length <= cfg_data;
    end
  end

  // The active side saturates at the grid size.
  assign active_n = (CMP_W'(side_length) > CMP_W'(SIDE_MAX)) ? CMP_W'(SIDE_MAX)
                                                             : CMP_W'(side_length);

  // Ring of row cells; the last cell takes the freshly updated row.
  for (genvar i = 0; i < SIDE_MAX; i++) begin : g_rows
    if (i == SIDE_MAX - 1) begin : g_tail
      lag_row_cell #(.SIDE(SIDE_MAX)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (new_row),
        .q     (rows[i])
      );
    end else begin : g_body
      lag_row_cell #(.SIDE(SIDE_MAX)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (rows[i+1]),
        .q     (rows[i])
      );
    end
  end

  // Column masks for the active square and the addressed column.
  for (genvar c = 0; c < SIDE_MAX; c++) begin : g_cols
    assign col_mask[c] = CMP_W'(c) < n_q;
    assign col_sel[c]  = CMP_W'(c) == CMP_W'(col_q);
  end

  // Neighbor rows around the head row; rows outside the square are dead.
  assign last_step = step == IDX_W'(SIDE_MAX - 1);
  assign in_square = (CMP_W'(row_q) < n_q) && (CMP_W'(col_q) < n_q);
  assign row_match = CMP_W'(step) == CMP_W'(row_q);
  assign above     = (step == '0) ? '0 : prev_row;
  assign below     = ((CMP_W'(step) + CMP_W'(1)) < n_q) ? rows[1] : '0;

  assign ctrl.op         = op_q;
  assign ctrl.row_active = CMP_W'(step) < n_q;
  assign ctrl.row_hit    = row_match && in_square;
  assign ctrl.val        = val_q;

  lag_row_update #(.SIDE(SIDE_MAX)) u_update (
    .above    (above),
    .cur      (rows[0]),
    .below    (below),
    .col_mask (col_mask),
    .col_sel  (col_sel),
    .ctrl     (ctrl),
    .new_row  (new_row)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    shift      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      lag_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = lag_pkg::ST_PASS;
        end
      end
      lag_pkg::ST_PASS: begin
        shift = 1'b1;
        if (last_step) begin
          state_next = lag_pkg::ST_FLUSH;
        end
      end
      lag_pkg::ST_FLUSH: begin
        state_next = lag_pkg::ST_DONE;
      end
      lag_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = lag_pkg::ST_IDLE;
        end
      end
      default: state_next = lag_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Captured item and side length for the pass.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= lag_pkg::lag_op_t'(op);
      row_q <= row;
      col_q <= col;
      val_q <= cell_in;
      n_q   <= active_n;
    end
  end

  // Step counter, previous row and addressed cell capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      step    <= '0;
      hit_bit <= 1'b0;
    end else if (shift) begin
      step     <= step + IDX_W'(1);
      prev_row <= rows[0];
      if (ctrl.row_hit) begin
        hit_bit <= |(new_row & col_sel);
      end
    end
  end

  // Live count: the active part of each new row is registered, then added.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_row_v <= 1'b0;
    end else begin
      cnt_row_v <= shift;
    end
  end

  always_ff @(posedge clk) begin
    cnt_row <= new_row & col_mask & {SIDE_MAX{ctrl.row_active}};
    if (accept) begin
      total <= '0;
    end else if (cnt_row_v) begin
      total <= total + popcount(cnt_row);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cell_out <= hit_bit;
      if (32'(total) > 32'(lag_pkg::COUNT_MAX)) begin
        live_count <= lag_pkg::COUNT_W'(lag_pkg::COUNT_MAX);
      end else begin
        live_count <= lag_pkg::COUNT_W'(total);
      end
    end
  end

`ifndef SYNTHESIS
  // The count pipeline has drained before a result is offered.
  a_count_drained: assert property (@(posedge clk) disable iff (rst)
    (state == lag_pkg::ST_DONE) |-> !cnt_row_v)
    else $error("count pipeline still busy at result time");

  // A pass covers exactly one full turn of the row ring.
  a_pass_length: assert property (@(posedge clk) disable iff (rst)
    (state == lag_pkg::ST_PASS && last_step) |=> (state == lag_pkg::ST_FLUSH))
    else $error("row pass did not end after a full turn");

  // The live count never exceeds the active square.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lag_pkg::ST_DONE) |-> (32'(total) <= 32'(n_q) * 32'(n_q)))
    else $error("live count exceeds the active square");

  // A cell is only captured inside the active square.
  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    (state == lag_pkg::ST_DONE && hit_bit) |-> in_square)
    else $error("cell captured outside the active square");
`endif

endmodule

@@ hdl/lag_row_cell.sv @@
module lag_row_cell #(
  parameter int SIDE = lag_pkg::SIDE_MAX_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic [SIDE-1:0] d,
  output logic [SIDE-1:0] q
);

  // One row of the grid; it takes the row at its input on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ hdl/lag_row_update.sv @@
module lag_row_update #(
  parameter int SIDE = lag_pkg::SIDE_MAX_DEFAULT
) (
  input  logic                  [SIDE-1:0] above,
  input  logic                  [SIDE-1:0] cur,
  input  logic                  [SIDE-1:0] below,
  input  logic                  [SIDE-1:0] col_mask,
  input  logic                  [SIDE-1:0] col_sel,
  input  lag_pkg::lag_upd_ctrl_t           ctrl,
  output logic                  [SIDE-1:0] new_row
);

  logic [SIDE+1:0] ap;
  logic [SIDE+1:0] cp;
  logic [SIDE+1:0] bp;
  logic [SIDE-1:0] life_row;

  // Inactive columns count as dead; the padding gives dead edge neighbors.
  assign ap = {1'b0, above & col_mask, 1'b0};
  assign cp = {1'b0, cur & col_mask, 1'b0};
  assign bp = {1'b0, below & col_mask, 1'b0};

  // Next generation of each column from its eight neighbors.
  always_comb begin
    logic [3:0] k;
    for (int c = 0; c < SIDE; c++) begin
      k = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
        + 4'(cp[c]) + 4'(cp[c+2])
        + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
      if (cp[c+1]) begin
        life_row[c] = (k >= lag_pkg::STAY_LOW) && (k <= lag_pkg::STAY_HIGH);
      end else begin
        life_row[c] = (k == lag_pkg::BIRTH_COUNT);
      end
      life_row[c] = life_row[c] & col_mask[c] & ctrl.row_active;
    end
  end

  // Select the new row for the operation in progress.
  always_comb begin
    unique case (ctrl.op)
      lag_pkg::OP_WRITE: begin
        if (ctrl.row_hit) begin
          new_row = (cur & ~col_sel) | (col_sel & {SIDE{ctrl.val}});
        end else begin
          new_row = cur;
        end
      end
      lag_pkg::OP_CLEAR:   new_row = '0;
      lag_pkg::OP_ADVANCE: new_row = life_row;
      lag_pkg::OP_READ:    new_row = cur;
      default:             new_row = cur;
    endcase
  end

endmodule

@@ tb/tb_life_automaton_grid_top.sv @@
module tb_life_automaton_grid_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX    = lag_pkg::SIDE_MAX_DEFAULT;
  localparam int CYCLE_LIMIT = 800000;
  localparam int REPORT_MAX  = 10;
  localparam int SEG_ITEMS   = 38;

  // One expected result: the addressed cell and the live count.
  typedef struct packed {
    logic                        alive;
    logic [lag_pkg::COUNT_W-1:0] count;
  } life_result_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic [lag_pkg::SIDE_W-1:0]  cfg_data  = lag_pkg::SIDE_RESET;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  lag_pkg::lag_op_t            op        = lag_pkg::OP_READ;
  logic [lag_pkg::ROW_W-1:0]   row       = '0;
  logic [lag_pkg::COL_W-1:0]   col       = '0;
  logic                        cell_in   = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        cell_out;
  logic [lag_pkg::COUNT_W-1:0] live_count;

  // Shadow copy of the grid and its side length.
  logic [lag_pkg::SIDE_W-1:0]  grid_side = lag_pkg::SIDE_RESET;
  bit [SIDE_MAX-1:0]           life_cells [SIDE_MAX];

  life_result_t                expected_q [$];
  int                          mismatch_count = 0;
  int                          cycle_count    = 0;
  int                          send_idle_pct  = 0;
  int                          recv_idle_pct  = 0;

  life_automaton_grid_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .row        (row),
    .col        (col),
    .cell_in    (cell_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_out   (cell_out),
    .live_count (live_count)
  );

  initial forever #6 clk = ~clk;

  // The side length saturates at the grid size.
  function automatic int live_side();
    if (int'(grid_side) > SIDE_MAX) return SIDE_MAX;
    return int'(grid_side);
  endfunction

  // Cells beyond the active square are dead; there is no wrap-around.
  function automatic int alive_at(int r, int c, int n);
    if (r < 0 || c < 0 || r >= n || c >= n) return 0;
    return int'(life_cells[r][c]);
  endfunction

  // One B3/S23 generation over the active square; cells outside it are cleared.
  function automatic void advance_generation(int n);
    bit [SIDE_MAX-1:0] next_cells [SIDE_MAX];
    int                k;
    for (int r = 0; r < SIDE_MAX; r++) begin
      for (int c = 0; c < SIDE_MAX; c++) begin
        next_cells[r][c] = 1'b0;
        if (r < n && c < n) begin
          k = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) k += alive_at(r + dr, c + dc, n);
            end
          end
          if (alive_at(r, c, n) != 0) begin
            next_cells[r][c] = (k >= int'(lag_pkg::STAY_LOW)) &&
                               (k <= int'(lag_pkg::STAY_HIGH));
          end else begin
            next_cells[r][c] = (k == int'(lag_pkg::BIRTH_COUNT));
          end
        end
      end
    end
    for (int r = 0; r < SIDE_MAX; r++) life_cells[r] = next_cells[r];
  endfunction

  function automatic logic [lag_pkg::COUNT_W-1:0] count_alive(int n);
    int total;
    total = 0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) total += int'(life_cells[r][c]);
    end
    if (total > lag_pkg::COUNT_MAX) total = lag_pkg::COUNT_MAX;
    return lag_pkg::COUNT_W'(total);
  endfunction

  // Apply one operation to the shadow grid and return what the block should report.
  function automatic life_result_t step_life(lag_pkg::lag_op_t kind,
                                             logic [lag_pkg::ROW_W-1:0] r,
                                             logic [lag_pkg::COL_W-1:0] c, logic v);
    life_result_t res;
    int           n;
    bit           hit;
    n   = live_side();
    hit = (int'(r) < n) && (int'(c) < n);
    case (kind)
      lag_pkg::OP_WRITE: begin
        if (hit) life_cells[r][c] = v;
      end
      lag_pkg::OP_CLEAR: begin
        for (int i = 0; i < SIDE_MAX; i++) life_cells[i] = '0;
      end
      lag_pkg::OP_ADVANCE: begin
        advance_generation(n);
      end
      default: begin
      end
    endcase
    res.alive = hit ? life_cells[r][c] : 1'b0;
    res.count = count_alive(n);
    return res;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
  endfunction

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    life_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: cell_out=%0b live_count=%0d",
                                cell_out, live_count));
      end else begin
        want = expected_q.pop_front();
        if (cell_out !== want.alive) begin
          flag_mismatch($sformatf("cell_out expected %0b actual %0b", want.alive, cell_out));
        end
        if (live_count !== want.count) begin
          flag_mismatch($sformatf("live_count expected %0d actual %0d",
                                  want.count, live_count));
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one item, hold it until the transfer, then record its expected result.
  task automatic send_item(lag_pkg::lag_op_t kind, logic [lag_pkg::ROW_W-1:0] r,
                           logic [lag_pkg::COL_W-1:0] c, logic v);
    life_result_t res;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    row      <= r;
    col      <= c;
    cell_in  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = step_life(kind, r, c, v);
    expected_q = {expected_q, res};
  endtask

  // Stop sending and wait until every result is back and the block takes input again.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_side(logic [lag_pkg::SIDE_W-1:0] side);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= side;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_side  = side;
  endtask

  // Mostly inside the active square, sometimes anywhere on the address range.
  function automatic logic [lag_pkg::ROW_W-1:0] pick_coord(int n);
    if ($urandom_range(0, 99) < 80) return lag_pkg::ROW_W'($urandom_range(0, n - 1));
    return lag_pkg::ROW_W'($urandom_range(0, SIDE_MAX - 1));
  endfunction

  // A freshly reset grid is empty at both corners.
  task automatic test_reset_state();
    send_item(lag_pkg::OP_READ, 5'd0, 5'd0, 1'b0);
    send_item(lag_pkg::OP_READ, 5'd31, 5'd31, 1'b1);
  endtask

  // Patterns against the top edge and the far corner see no wrap-around.
  task automatic test_edges();
    send_item(lag_pkg::OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd0, 5'd1, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd0, 5'd2, 1'b1);
    send_item(lag_pkg::OP_ADVANCE, 5'd1, 5'd1, 1'b0);
    send_item(lag_pkg::OP_ADVANCE, 5'd0, 5'd1, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd30, 5'd30, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd30, 5'd31, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd31, 5'd30, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd31, 5'd31, 1'b1);
    send_item(lag_pkg::OP_ADVANCE, 5'd31, 5'd31, 1'b0);
  endtask

  task automatic test_clear();
    send_item(lag_pkg::OP_CLEAR, 5'd31, 5'd31, 1'b1);
  endtask

  // Cells outside the square keep their value until a generation clears them.
  task automatic test_square_bounds();
    set_side(6'd32);
    send_item(lag_pkg::OP_WRITE, 5'd20, 5'd20, 1'b1);
    set_side(6'd4);
    send_item(lag_pkg::OP_WRITE, 5'd5, 5'd5, 1'b1);
    send_item(lag_pkg::OP_WRITE, 5'd3, 5'd3, 1'b1);
    send_item(lag_pkg::OP_READ, 5'd20, 5'd20, 1'b0);
    set_side(6'd32);
    send_item(lag_pkg::OP_READ, 5'd20, 5'd20, 1'b0);
    set_side(6'd4);
    send_item(lag_pkg::OP_ADVANCE, 5'd3, 5'd3, 1'b0);
    set_side(6'd32);
    send_item(lag_pkg::OP_READ, 5'd20, 5'd20, 1'b0);
  endtask

  // An empty square, a side above the grid size, and a single cell.
  task automatic test_side_extremes();
    set_side(6'd0);
    send_item(lag_pkg::OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(lag_pkg::OP_ADVANCE, 5'd0, 5'd0, 1'b0);
    set_side(6'd63);
    send_item(lag_pkg::OP_WRITE, 5'd31, 5'd31, 1'b1);
    send_item(lag_pkg::OP_READ, 5'd31, 5'd31, 1'b0);
    set_side(6'd1);
    send_item(lag_pkg::OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(lag_pkg::OP_ADVANCE, 5'd0, 5'd1, 1'b0);
  endtask

  // Seed a random patch, let it evolve a few generations, with some noise mixed in.
  task automatic life_segment(int n_items);
    int                        sent;
    int                        n;
    int                        span;
    int                        r0;
    int                        c0;
    logic [lag_pkg::ROW_W-1:0] r;
    logic [lag_pkg::COL_W-1:0] c;
    lag_pkg::lag_op_t          kind;
    sent = 0;
    n    = live_side();
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        send_item(lag_pkg::lag_op_t'($urandom_range(0, 3)),
                  lag_pkg::ROW_W'($urandom_range(0, 31)),
                  lag_pkg::COL_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send_item(lag_pkg::OP_CLEAR, pick_coord(n), pick_coord(n),
                    1'($urandom_range(0, 1)));
          sent++;
        end
        span = (n < 8) ? n : 8;
        r0   = $urandom_range(0, n - span);
        c0   = $urandom_range(0, n - span);
        repeat ($urandom_range(3, span * span / 2 + 3)) begin
          if (sent < n_items) begin
            r = lag_pkg::ROW_W'(r0 + $urandom_range(0, span - 1));
            c = lag_pkg::COL_W'(c0 + $urandom_range(0, span - 1));
            if ($urandom_range(0, 99) < 10) begin
              r = lag_pkg::ROW_W'($urandom_range(0, 31));
              c = lag_pkg::COL_W'($urandom_range(0, 31));
            end
            send_item(lag_pkg::OP_WRITE, r, c, $urandom_range(0, 99) < 70);
            sent++;
          end
        end
        repeat ($urandom_range(2, 8)) begin
          if (sent < n_items) begin
            kind = ($urandom_range(0, 3) == 0) ? lag_pkg::OP_READ : lag_pkg::OP_ADVANCE;
            send_item(kind, pick_coord(n), pick_coord(n), 1'($urandom_range(0, 1)));
            sent++;
          end
        end
      end
    end
  endtask

  // Random life traffic over a series of side lengths, at one idling mix.
  task automatic test_random_life(int send_pct, int recv_pct);
    logic [lag_pkg::SIDE_W-1:0] side;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int seg = 0; seg < 9; seg++) begin
      case (seg)
        0: side = 6'd32;
        1: side = 6'd6;
        2: side = 6'd1;
        3: side = 6'd20;
        4: side = 6'd63;
        5: side = 6'd3;
        6: side = 6'd11;
        7: side = 6'd2;
        default: side = 6'd32;
      endcase
      set_side(side);
      life_segment(SEG_ITEMS);
    end
  endtask

  initial begin
    send_idle_pct = 25;
    recv_idle_pct = 49;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_edges();
    test_clear();
    test_square_bounds();
    test_side_extremes();
    test_random_life(25, 49);
    test_random_life(49, 25);
    test_random_life(0, 0);
    wait_idle();
    repeat (SIDE_MAX + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lag_pkg.sv
hdl/lag_row_cell.sv
hdl/lag_row_update.sv
hdl/life_automaton_grid_top.sv
tb/tb_life_automaton_grid_top.sv
